[hdl/bxavg_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the box average downscaler
package bxavg_pkg;

  localparam int CHAN_W  = 8;
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int FACT_W  = 5;
  localparam int CNT_W   = 10;  // pixels in one block, up to 31 * 31
  localparam int RUN_W   = 13;  // one block row of one channel
  localparam int SUM_W   = 18;  // whole block of one channel
  localparam int NUM_CHAN = 4;

  localparam int MAX_DIM         = 4096;
  localparam int DEF_MAX_COLUMNS = 4096;
  localparam int DEF_MAX_FACTOR  = 16;

  localparam int OP_QUEUE_DEPTH     = 4;
  localparam int RESULT_QUEUE_DEPTH = 2;

  // average fits in a channel, so one quotient bit per channel and step
  localparam int QUOT_STEPS = CHAN_W;
  localparam int QSTEP_W    = $clog2(QUOT_STEPS);

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd2;

  localparam logic [DIM_W-1:0]  RESET_WIDTH  = 13'd512;
  localparam logic [DIM_W-1:0]  RESET_HEIGHT = 13'd512;
  localparam logic [FACT_W-1:0] RESET_FACTOR = 5'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  out_red;
    logic [CHAN_W-1:0]  out_green;
    logic [CHAN_W-1:0]  out_blue;
    logic [CHAN_W-1:0]  out_alpha;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    logic               image_done;
  } result_t;

  // saturated image geometry and derived block sizes
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [FACT_W-1:0] factor;
    logic [FACT_W-1:0] block_w;
    logic [FACT_W-1:0] block_h;
    logic [CNT_W-1:0]  count;
    logic              narrow_w;
    logic              narrow_h;
  } geom_t;

  // one finished block row segment, handed from front to back
  typedef struct packed {
    logic [NUM_CHAN-1:0][RUN_W-1:0] run;
    logic [COORD_W-1:0]             column;
    logic [COORD_W-1:0]             row;
    logic                           first_row;
    logic                           last_row;
    logic                           done;
    logic [CNT_W-1:0]               count;
  } op_t;

endpackage

[hdl/bxavg_fifo.sv]
`timescale 1ns / 1ps
// small synchronous fifo used between the stages
module bxavg_fifo import bxavg_pkg::*; #(
  parameter int WIDTH = CHAN_W,
  parameter int DEPTH = RESULT_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == FILL_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: fill <= fill + 1'b1;
        2'b01: fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hdl/bxavg_front.sv]
`timescale 1ns / 1ps
// front: tracks the raster position, sums each block row segment, issues ops
module bxavg_front import bxavg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  geom_t  geom,
  input  logic   push,
  input  pixel_t pixel,
  output logic   full,
  output logic   op_push,
  output op_t    op,
  input  logic   op_full
);

  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [FACT_W-1:0]  cm;
  logic [FACT_W-1:0]  rm;
  logic [DIM_W-1:0]   bs;
  logic [DIM_W-1:0]   brs;
  logic [COORD_W-1:0] oc;
  logic [COORD_W-1:0] orow;
  logic [NUM_CHAN-1:0][RUN_W-1:0] run;
  logic [NUM_CHAN-1:0][RUN_W-1:0] run_next;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] px;

  logic [DIM_W:0] f_ext;
  logic [DIM_W:0] w_ext;
  logic [DIM_W:0] h_ext;
  logic           accept;
  logic           col_in;
  logic           row_in;
  logic           col_last_blk;
  logic           row_last_blk;
  logic           col_end;
  logic           row_end;
  logic           col_wrap;
  logic           row_wrap;
  logic           cm_wrap;
  logic           rm_wrap;
  logic           in_range;

  assign px[0] = pixel.in_red;
  assign px[1] = pixel.in_green;
  assign px[2] = pixel.in_blue;
  assign px[3] = pixel.in_alpha;

  assign full   = op_full;
  assign accept = push && !op_full;

  assign f_ext = (DIM_W + 1)'(geom.factor);
  assign w_ext = (DIM_W + 1)'(geom.width);
  assign h_ext = (DIM_W + 1)'(geom.height);

  // a block is kept when it lies wholly inside the image, or the image is smaller than the factor there
  assign col_in = geom.narrow_w || ((DIM_W + 1)'(bs) + f_ext <= w_ext);
  assign row_in = geom.narrow_h || ((DIM_W + 1)'(brs) + f_ext <= h_ext);
  assign col_last_blk = geom.narrow_w || ((DIM_W + 1)'(bs) + f_ext + f_ext > w_ext);
  assign row_last_blk = geom.narrow_h || ((DIM_W + 1)'(brs) + f_ext + f_ext > h_ext);
  assign in_range = col_in && row_in;

  assign col_end  = (cm == geom.block_w - FACT_W'(1));
  assign row_end  = (rm == geom.block_h - FACT_W'(1));
  assign cm_wrap  = (cm == geom.factor - FACT_W'(1));
  assign rm_wrap  = (rm == geom.factor - FACT_W'(1));
  assign col_wrap = (DIM_W'(col) >= geom.width - DIM_W'(1));
  assign row_wrap = (DIM_W'(row) >= geom.height - DIM_W'(1));

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      run_next[k] = ((cm == '0) ? '0 : run[k]) + RUN_W'(px[k]);
    end
  end

  assign op_push      = accept && in_range && col_end;
  assign op.run       = run_next;
  assign op.column    = oc;
  assign op.row       = orow;
  assign op.first_row = (rm == '0);
  assign op.last_row  = row_end;
  assign op.done      = col_last_blk && row_last_blk;
  assign op.count     = geom.count;

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      run <= run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      cm   <= '0;
      bs   <= '0;
      oc   <= '0;
      row  <= '0;
      rm   <= '0;
      brs  <= '0;
      orow <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        cm  <= '0;
        bs  <= '0;
        oc  <= '0;
        if (row_wrap) begin
          row  <= '0;
          rm   <= '0;
          brs  <= '0;
          orow <= '0;
        end else begin
          row <= row + 1'b1;
          if (rm_wrap) begin
            rm   <= '0;
            brs  <= brs + DIM_W'(geom.factor);
            orow <= orow + 1'b1;
          end else begin
            rm <= rm + 1'b1;
          end
        end
      end else begin
        col <= col + 1'b1;
        if (cm_wrap) begin
          cm <= '0;
          bs <= bs + DIM_W'(geom.factor);
          oc <= oc + 1'b1;
        end else begin
          cm <= cm + 1'b1;
        end
      end
    end
  end

endmodule

[hdl/bxavg_div.sv]
`timescale 1ns / 1ps
// four-lane restoring divider, one quotient bit per lane and cycle
module bxavg_div import bxavg_pkg::*; (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [NUM_CHAN-1:0][SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]                 divisor,
  output logic                             busy,
  output logic [NUM_CHAN-1:0][CHAN_W-1:0]  quotient
);

  logic [NUM_CHAN-1:0][SUM_W-1:0] rem;
  logic [SUM_W-1:0]               dsh;
  logic [QSTEP_W-1:0]             step;

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= SUM_W'(divisor) << (QUOT_STEPS - 1);
      quotient <= '0;
    end else if (busy) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        if (rem[k] >= dsh) begin
          rem[k]      <= rem[k] - dsh;
          quotient[k] <= {quotient[k][CHAN_W-2:0], 1'b1};
        end else begin
          quotient[k] <= {quotient[k][CHAN_W-2:0], 1'b0};
        end
      end
      dsh <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= QSTEP_W'(QUOT_STEPS - 1);
    end else if (busy) begin
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

endmodule

[hdl/bxavg_back.sv]
`timescale 1ns / 1ps
// back: adds block row segments into the column sums and averages finished blocks
module bxavg_back import bxavg_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    op_empty,
  input  op_t     op_head,
  output logic    op_pop,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  localparam int ADDR_W = $clog2(MAX_COLUMNS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [NUM_CHAN-1:0][SUM_W-1:0] sums_mem [MAX_COLUMNS];

  logic [1:0]                      state;
  op_t                             op_q;
  logic [NUM_CHAN-1:0][SUM_W-1:0]  rdata;
  logic [NUM_CHAN-1:0][SUM_W-1:0]  fwd_data;
  logic                            fwd;
  logic [NUM_CHAN-1:0][SUM_W-1:0]  base;
  logic [NUM_CHAN-1:0][SUM_W-1:0]  total;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] quotient;
  logic                            free;
  logic                            wr_en;
  logic                            div_start;
  logic                            div_busy;
  logic [ADDR_W-1:0]               rd_addr;
  logic [ADDR_W-1:0]               wr_addr;

  // a sum written at the same edge it is read comes from the bypass
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      base[k]  = op_q.first_row ? '0 : (fwd ? fwd_data[k] : rdata[k]);
      total[k] = base[k] + SUM_W'(op_q.run[k]);
    end
  end

  assign free      = (state == ST_IDLE) || ((state == ST_ACC) && !op_q.last_row);
  assign op_pop    = free && !op_empty;
  assign wr_en     = (state == ST_ACC);
  assign div_start = (state == ST_ACC) && op_q.last_row;
  assign rd_addr   = ADDR_W'(op_head.column);
  assign wr_addr   = ADDR_W'(op_q.column);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sums_mem[wr_addr] <= total;
    end
    if (op_pop) begin
      rdata <= sums_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      op_q     <= op_head;
      fwd      <= (state == ST_ACC) && (op_q.column == op_head.column);
      fwd_data <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (op_pop) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (op_q.last_row) begin
            state <= ST_DIV;
          end else if (!op_pop) begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (!div_busy && !res_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bxavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total),
    .divisor  (op_q.count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign res_push       = (state == ST_DIV) && !div_busy && !res_full;
  assign res.out_red    = quotient[0];
  assign res.out_green  = quotient[1];
  assign res.out_blue   = quotient[2];
  assign res.out_alpha  = quotient[3];
  assign res.out_column = op_q.column;
  assign res.out_row    = op_q.row;
  assign res.image_done = op_q.done;

endmodule

[hdl/box_average_downscaler_unit.sv]
`timescale 1ns / 1ps
// Box average downscaler: shrinks an RGBA raster stream by an integer factor.
// Source pixels enter through push/full in raster order; an item is taken on
// a clock edge with push high and full low. Averaged pixels leave through
// empty/pop; the oldest result sits on the result port while empty is low and
// is taken on an edge with pop high. Geometry is set with cfg_write,
// cfg_index and cfg_data; the user must write it only between images,
// which the block does not enforce. The front takes one pixel per cycle
// while the op queue is not full and hands each finished block row segment
// to a four-entry queue. The back takes segments that do not end a block
// back to back; one that ends a block is accumulated, divided and handed
// off, then the back idles, taking no new segment while it divides. With a
// factor of 11 or more and an image at least one block wide the stream runs
// at one pixel per cycle while results are taken; otherwise the divider sets
// the rate. A block's result goes via the op queue, divider and output queue.
// When the receiver stalls, results wait in a two-entry output queue, then
// the back stops, the op queue fills and full rises.
// Reset empties both queues, puts the position at the top left and sets
// 512 x 512 with factor 2; the column sums need no clearing.
module box_average_downscaler_unit import bxavg_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_FACTOR  = DEF_MAX_FACTOR
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  pixel_t               pixel,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result
);

  localparam int WIDTH_MAX = (MAX_COLUMNS < MAX_DIM) ? MAX_COLUMNS : MAX_DIM;

  logic [DIM_W-1:0]  source_width;
  logic [DIM_W-1:0]  source_height;
  logic [FACT_W-1:0] scale_factor;

  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;
  logic [FACT_W-1:0] f;
  geom_t             geom;

  logic    op_push;
  op_t     op;
  logic    op_full;
  logic    op_pop;
  op_t     op_head;
  logic    op_empty;
  logic    res_push;
  result_t res;
  logic    res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RESET_WIDTH;
      source_height <= RESET_HEIGHT;
      scale_factor  <= RESET_FACTOR;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_SCALE_FACTOR:  scale_factor  <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate the registers to their usable ranges
  assign w = (source_width == '0) ? DIM_W'(1) :
             (int'(source_width) > WIDTH_MAX) ? DIM_W'(WIDTH_MAX) : source_width;
  assign h = (source_height == '0) ? DIM_W'(1) :
             (int'(source_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : source_height;
  assign f = (scale_factor == '0) ? FACT_W'(1) :
             (int'(scale_factor) > MAX_FACTOR) ? FACT_W'(MAX_FACTOR) : scale_factor;

  assign geom.width    = w;
  assign geom.height   = h;
  assign geom.factor   = f;
  assign geom.narrow_w = (w < DIM_W'(f));
  assign geom.narrow_h = (h < DIM_W'(f));
  assign geom.block_w  = geom.narrow_w ? w[FACT_W-1:0] : f;
  assign geom.block_h  = geom.narrow_h ? h[FACT_W-1:0] : f;
  assign geom.count    = CNT_W'(geom.block_w) * CNT_W'(geom.block_h);

  bxavg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .push    (push),
    .pixel   (pixel),
    .full    (full),
    .op_push (op_push),
    .op      (op),
    .op_full (op_full)
  );

  bxavg_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OP_QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .din   (op),
    .full  (op_full),
    .pop   (op_pop),
    .dout  (op_head),
    .empty (op_empty)
  );

  bxavg_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_empty (op_empty),
    .op_head  (op_head),
    .op_pop   (op_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  bxavg_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

  a_op_no_overflow: assert property (@(posedge clk) disable iff (rst)
    op_push |-> !op_full)
    else $error("op issued into a full op queue");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result issued into a full output queue");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    op_pop |-> !op_empty)
    else $error("back took an op from an empty queue");

endmodule
